/* rtl/motor_thermal_overload_guard_assert.svh */
// ----------------------------------------------------------------------------
// motor thermal overload guard assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MOTOR_THERMAL_OVERLOAD_GUARD_ASSERT_SVH
`define MOTOR_THERMAL_OVERLOAD_GUARD_ASSERT_SVH

// same-cycle implication
`define MTOG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtog check failed");

// next-cycle implication
`define MTOG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtog check failed");

`endif

/* rtl/mtog_pkg.sv */
// ----------------------------------------------------------------------------
// mtog_pkg
// shared types, constants and table functions of the thermal overload guard
// ----------------------------------------------------------------------------
package mtog_pkg;

  localparam int MA_W = 52;
  localparam int MB_W = 33;
  localparam int MP_W = 85;
  localparam int DN_W = 52;
  localparam int DV_W = 35;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic [2:0] CFG_SUPPLY = 3'd0;
  localparam logic [2:0] CFG_RESIST = 3'd1;
  localparam logic [2:0] CFG_BEMF   = 3'd2;
  localparam logic [2:0] CFG_TAU    = 3'd3;
  localparam logic [2:0] CFG_PROT   = 3'd4;
  localparam logic [2:0] CFG_EMERG  = 3'd5;
  localparam logic [2:0] CFG_SWITCH = 3'd6;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_ELEVATED = 2'd1;
  localparam logic [1:0] MODE_PROTECT  = 2'd2;
  localparam logic [1:0] MODE_EMERG    = 2'd3;

  localparam logic [15:0] FRIC_BASE   = 16'd3277;
  localparam logic [15:0] FRIC_SLOPE  = 16'd1311;
  localparam logic [15:0] SW_BASE     = 16'd655;
  localparam logic [15:0] SW_SLOPE    = 16'd3277;
  localparam logic [15:0] STALL_DUTY  = 16'd9830;
  localparam logic [15:0] STALL_SPEED = 16'd128;
  localparam logic [6:0]  K_100       = 7'd100;
  localparam logic [6:0]  K_95        = 7'd95;
  localparam logic [6:0]  K_85        = 7'd85;
  localparam logic [6:0]  K_10        = 7'd10;
  localparam logic [2:0]  K_5         = 3'd5;
  localparam logic [9:0]  K_1000      = 10'd1000;
  localparam logic [16:0] SCALE_ONE   = 17'd65536;
  localparam logic [16:0] SCALE_MIN   = 17'd39322;
  localparam logic [16:0] RED_MAX     = 17'd26214;
  localparam logic [32:0] Q32_ONE     = 33'h1_0000_0000;
  localparam int          INT_POWERS  = 24;

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] m);
    return (a >> 32) * m + (((a & 64'hFFFF_FFFF) * m) >> 32);
  endfunction

  function automatic logic [63:0] exp_series(input logic [63:0] h);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'h1_0000_0000;
    term = 64'h1_0000_0000;
    for (int k = 1; k <= 16; k++) begin
      term = mul_q32(term, h) / 64'(k);
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [32:0] frac_entry(input int k, input logic [63:0] r);
    logic [63:0] v;
    v = 64'h1_0000_0000;
    for (int i = 0; i < k; i++) v = mul_q32(v, r);
    return v[32:0];
  endfunction

  function automatic logic [32:0] int_entry(input int n);
    logic [63:0] v;
    logic [63:0] e1;
    v  = 64'h1_0000_0000;
    e1 = exp_series(64'h1_0000_0000);
    for (int i = 0; i < n; i++) v = mul_q32(v, e1);
    return (n >= INT_POWERS) ? 33'd0 : v[32:0];
  endfunction

endpackage

/* rtl/motor_thermal_overload_guard.sv */
// ----------------------------------------------------------------------------
// motor_thermal_overload_guard
// heating power, decaying energy integral and four-level derating of the duty
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb up)                              tuser
// s_axis   in   duty[15:0] speed[31:16] time_ms[63:32]            kind
// m_axis   out  limited_command[15:0] state_code[17:16]           -
//               energy[49:18] power[81:50] protection_active[82]
//               emergency_active[83] zero[87:84]
// cfg      in   cfg_idx_i selects, cfg_data_i written on cfg_we_i  -
//
// one item at a time, its duration set by the bit-serial multiplier, which stops
// early once no multiplier bits are left, and by the restoring divides
// the first item or a bad step skips the decay path and takes the short end
// the result sits in an output register; a new beat is taken while it waits
// reset clears state, mode and registers to their defaults, no clearing pass
// ----------------------------------------------------------------------------
`include "motor_thermal_overload_guard_assert.svh"

module motor_thermal_overload_guard #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int MAX_STEP_MS     = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // duty, speed, time_ms
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // limited_command, state_code, energy, power,
                                      // protection_active, emergency_active
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import mtog_pkg::*;

  localparam int IDXW = $clog2(EXP_TABLE_DEPTH);
  localparam int DTW  = $clog2(MAX_STEP_MS + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DRV  = 5'd1;
  localparam logic [4:0] S_EMF  = 5'd2;
  localparam logic [4:0] S_SQ   = 5'd3;
  localparam logic [4:0] S_PDIV = 5'd4;
  localparam logic [4:0] S_FRI  = 5'd5;
  localparam logic [4:0] S_SWA  = 5'd6;
  localparam logic [4:0] S_SWB  = 5'd7;
  localparam logic [4:0] S_PFIN = 5'd8;
  localparam logic [4:0] S_XDIV = 5'd9;
  localparam logic [4:0] S_POS  = 5'd10;
  localparam logic [4:0] S_ROM  = 5'd11;
  localparam logic [4:0] S_LERP = 5'd12;
  localparam logic [4:0] S_DEC  = 5'd13;
  localparam logic [4:0] S_E1   = 5'd14;
  localparam logic [4:0] S_HT   = 5'd15;
  localparam logic [4:0] S_HM   = 5'd16;
  localparam logic [4:0] S_HDIV = 5'd17;
  localparam logic [4:0] S_M100 = 5'd18;
  localparam logic [4:0] S_M95  = 5'd19;
  localparam logic [4:0] S_M85  = 5'd20;
  localparam logic [4:0] S_M10  = 5'd21;
  localparam logic [4:0] S_MODE = 5'd22;
  localparam logic [4:0] S_SCL  = 5'd23;
  localparam logic [4:0] S_DEN5 = 5'd24;
  localparam logic [4:0] S_RDIV = 5'd25;
  localparam logic [4:0] S_OUT  = 5'd26;
  localparam logic [4:0] S_DONE = 5'd27;

  // configuration
  logic [15:0] sv_q, rw_q, bk_q, sc_q;
  logic [19:0] tc_q;
  logic [31:0] pl_q, el_q;

  // block state
  logic [1:0]  mode_q, mode_d;
  logic [31:0] e_q, hp_q, lt_q;
  logic [15:0] sd_q, ss_q;

  // sequencer
  logic [4:0]  st_q, st_d;
  logic        go_q, go_d;
  logic        m_valid_q;
  logic [87:0] out_q;

  // work registers
  logic [31:0]     ts_q;
  logic [23:0]     drive_q, veff_q;
  logic [51:0]     t_q;
  logic [42:0]     pacc_q;
  logic [11:0]     swt_q;
  logic [DTW-1:0]  dt_q;
  logic [47:0]     x_q;
  logic [IDXW-1:0] idx_q;
  logic [4:0]      n_q;
  logic [31:0]     frac_q;
  logic [32:0]     v_q, d_q;
  logic [31:0]     e1_q;
  logic [38:0]     k100_q, k95_q, k85_q, k10_q;
  logic [34:0]     den5_q;
  logic [16:0]     scale_q;
  logic [15:0]     cmd_q;

  // units
  logic             mul_go, div_go;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MP_W-1:0]  mul_p;
  unit_stat_t       mul_st, div_st;
  logic [DN_W-1:0]  div_n, div_q;
  logic [DV_W-1:0]  div_d;
  logic [32:0]      rom_a, rom_b, rom_i;

  logic        is_mul, is_div, fin, accept, out_free;
  logic [15:0] ad, as_mag;
  logic [19:0] tau;
  logic [15:0] rdiv;
  logic [31:0] dt32, e_pl, el_pl;
  logic        stall;
  logic [45:0] pstall;
  logic [23:0] emf;
  logic [42:0] esum;
  logic [IDXW-1:0] idx_raw;
  logic [15:0] mag;

  assign ad     = sd_q[15] ? 16'(-sd_q) : sd_q;
  assign as_mag = ss_q[15] ? 16'(-ss_q) : ss_q;
  assign tau    = (tc_q == '0) ? 20'd1 : tc_q;
  assign rdiv   = (rw_q == '0) ? 16'd1 : rw_q;
  assign dt32   = ts_q - lt_q;
  assign e_pl   = e_q - pl_q;
  assign el_pl  = el_q - pl_q;
  assign stall  = (ad > STALL_DUTY) && (as_mag < STALL_SPEED);
  assign pstall = stall ? 46'((46'(pacc_q) + (46'(pacc_q) << 2)) >> 1) : 46'(pacc_q);
  assign emf    = mul_p[31:8];
  assign esum   = 43'(e1_q) + 43'(div_q[41:0]);
  assign idx_raw = mul_p[32 +: IDXW];
  assign mag    = mul_p[31:16];

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fin           = go_q && (mul_st.done || div_st.done);

  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (st_q)
      S_DRV:  begin mul_a = MA_W'(sv_q);    mul_b = MB_W'(ad);       end
      S_EMF:  begin mul_a = MA_W'(bk_q);    mul_b = MB_W'(as_mag);   end
      S_SQ:   begin mul_a = MA_W'(veff_q);  mul_b = MB_W'(veff_q);   end
      S_FRI:  begin mul_a = MA_W'(as_mag);  mul_b = MB_W'(FRIC_SLOPE); end
      S_SWA:  begin mul_a = MA_W'(ad);      mul_b = MB_W'(SW_SLOPE); end
      S_SWB:  begin mul_a = MA_W'(swt_q);   mul_b = MB_W'(sc_q);     end
      S_POS:  begin mul_a = MA_W'(x_q[31:0]); mul_b = MB_W'(EXP_TABLE_DEPTH - 1); end
      S_LERP: begin mul_a = MA_W'(rom_a - rom_b); mul_b = MB_W'(frac_q); end
      S_DEC:  begin mul_a = MA_W'(rom_i);   mul_b = v_q;             end
      S_E1:   begin mul_a = MA_W'(e_q);     mul_b = d_q;             end
      S_HT:   begin mul_a = MA_W'(hp_q);    mul_b = MB_W'(tau);      end
      S_HM:   begin mul_a = t_q;            mul_b = Q32_ONE - d_q;   end
      S_M100: begin mul_a = MA_W'(e_q);     mul_b = MB_W'(K_100);    end
      S_M95:  begin mul_a = MA_W'(pl_q);    mul_b = MB_W'(K_95);     end
      S_M85:  begin mul_a = MA_W'(pl_q);    mul_b = MB_W'(K_85);     end
      S_M10:  begin mul_a = MA_W'(e_q);     mul_b = MB_W'(K_10);     end
      S_DEN5: begin mul_a = MA_W'(el_pl);   mul_b = MB_W'(K_5);      end
      S_OUT:  begin mul_a = MA_W'(ad);      mul_b = MB_W'(scale_q);  end
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    is_div = 1'b1;
    div_n  = '0;
    div_d  = '0;
    unique case (st_q)
      S_PDIV: begin div_n = DN_W'(t_q[47:0]);       div_d = DV_W'({rdiv, 8'h00}); end
      S_XDIV: begin div_n = DN_W'({dt_q, 32'h0});   div_d = DV_W'(tau);           end
      S_HDIV: begin div_n = t_q;                    div_d = DV_W'(K_1000);        end
      S_RDIV: begin div_n = DN_W'({e_pl, 17'h0});   div_d = den5_q;               end
      default: is_div = 1'b0;
    endcase
  end

  assign mul_go = is_mul && !go_q;
  assign div_go = is_div && !go_q;

  // hysteresis on the fresh energy
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      MODE_NORMAL: begin
        if (k100_q > k95_q) mode_d = MODE_ELEVATED;
      end
      MODE_ELEVATED: begin
        priority if (e_q > pl_q) mode_d = MODE_PROTECT;
        else if (k100_q < k85_q) mode_d = MODE_NORMAL;
      end
      MODE_PROTECT: begin
        priority if (e_q > el_q) mode_d = MODE_EMERG;
        else if ({e_q, 1'b0} < {1'b0, pl_q}) mode_d = MODE_NORMAL;
      end
      default: begin
        if (k10_q < 39'({el_q, 2'b00})) mode_d = MODE_NORMAL;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    go_d = go_q;
    if (is_mul || is_div) begin
      if (!go_q) go_d = 1'b1;
      else if (fin) go_d = 1'b0;
    end
    unique case (st_q)
      S_IDLE: if (accept) st_d = S_DRV;
      S_DRV:  if (fin) st_d = S_EMF;
      S_EMF:  if (fin) st_d = S_SQ;
      S_SQ:   if (fin) st_d = S_PDIV;
      S_PDIV: if (fin) st_d = S_FRI;
      S_FRI:  if (fin) st_d = S_SWA;
      S_SWA:  if (fin) st_d = S_SWB;
      S_SWB:  if (fin) st_d = S_PFIN;
      S_PFIN: begin
        if (lt_q == '0 || dt32 == '0 || dt32 > 32'(MAX_STEP_MS)) st_d = S_M100;
        else st_d = S_XDIV;
      end
      S_XDIV: if (fin) st_d = (div_q[47:32] >= 16'(INT_POWERS)) ? S_E1 : S_POS;
      S_POS:  if (fin) st_d = S_ROM;
      S_ROM:  st_d = S_LERP;
      S_LERP: if (fin) st_d = S_DEC;
      S_DEC:  if (fin) st_d = S_E1;
      S_E1:   if (fin) st_d = S_HT;
      S_HT:   if (fin) st_d = S_HM;
      S_HM:   if (fin) st_d = S_HDIV;
      S_HDIV: if (fin) st_d = S_M100;
      S_M100: if (fin) st_d = S_M95;
      S_M95:  if (fin) st_d = S_M85;
      S_M85:  if (fin) st_d = S_M10;
      S_M10:  if (fin) st_d = S_MODE;
      S_MODE: st_d = S_SCL;
      S_SCL: begin
        if (mode_q == MODE_PROTECT && el_q > pl_q && e_q > pl_q && e_pl < el_pl)
          st_d = S_DEN5;
        else st_d = S_OUT;
      end
      S_DEN5: if (fin) st_d = S_RDIV;
      S_RDIV: if (fin) st_d = S_OUT;
      S_OUT:  if (fin) st_d = S_DONE;
      S_DONE: if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // control, configuration and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      go_q      <= 1'b0;
      m_valid_q <= 1'b0;
      sv_q      <= 16'd3072;
      rw_q      <= 16'd512;
      bk_q      <= 16'd655;
      tc_q      <= 20'd30000;
      pl_q      <= 32'd6553600;
      el_q      <= 32'd9830400;
      sc_q      <= 16'd256;
      mode_q    <= MODE_NORMAL;
      e_q       <= '0;
      hp_q      <= '0;
      lt_q      <= '0;
      sd_q      <= '0;
      ss_q      <= '0;
    end else begin
      st_q <= st_d;
      go_q <= go_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SUPPLY: sv_q <= cfg_data_i[15:0];
          CFG_RESIST: rw_q <= cfg_data_i[15:0];
          CFG_BEMF:   bk_q <= cfg_data_i[15:0];
          CFG_TAU:    tc_q <= cfg_data_i[19:0];
          CFG_PROT:   pl_q <= cfg_data_i;
          CFG_EMERG:  el_q <= cfg_data_i;
          CFG_SWITCH: sc_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (accept && !s_axis_tuser) begin
        sd_q <= s_axis_tdata[15:0];
        ss_q <= s_axis_tdata[31:16];
      end
      if (st_q == S_PFIN) begin
        hp_q <= (pstall > 46'hFFFF_FFFF) ? 32'hFFFF_FFFF : pstall[31:0];
        lt_q <= ts_q;
      end
      if (st_q == S_HDIV && fin) begin
        e_q <= (esum > 43'hFFFF_FFFF) ? 32'hFFFF_FFFF : esum[31:0];
      end
      if (st_q == S_MODE) mode_q <= mode_d;
      if (st_q == S_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) ts_q <= s_axis_tdata[63:32];
    if (fin) begin
      unique case (st_q)
        S_DRV:  drive_q <= mul_p[30:7];
        S_EMF:  veff_q  <= (drive_q > emf) ? drive_q - emf : '0;
        S_SQ:   t_q     <= MA_W'(mul_p[47:0]);
        S_PDIV: pacc_q  <= 43'(div_q[40:0]);
        S_FRI:  pacc_q  <= pacc_q + 43'(FRIC_BASE) + 43'(mul_p[25:8]);
        S_SWA:  swt_q   <= 12'(SW_BASE) + mul_p[26:15];
        S_SWB:  pacc_q  <= pacc_q + 43'(mul_p[27:8]);
        S_XDIV: begin
          x_q <= div_q[47:0];
          n_q <= div_q[36:32];
          d_q <= '0;
        end
        S_POS: begin
          idx_q  <= (idx_raw > IDXW'(EXP_TABLE_DEPTH - 2)) ?
                    IDXW'(EXP_TABLE_DEPTH - 2) : idx_raw;
          frac_q <= mul_p[31:0];
        end
        S_LERP: v_q    <= rom_a - mul_p[64:32];
        S_DEC:  d_q    <= mul_p[64:32];
        S_E1:   e1_q   <= mul_p[63:32];
        S_HT:   t_q    <= mul_p[51:0];
        S_HM:   t_q    <= mul_p[83:32];
        S_M100: k100_q <= mul_p[38:0];
        S_M95:  k95_q  <= mul_p[38:0];
        S_M85:  k85_q  <= mul_p[38:0];
        S_M10:  k10_q  <= mul_p[38:0];
        S_DEN5: den5_q <= mul_p[34:0];
        S_RDIV: scale_q <= (div_q > DN_W'(RED_MAX)) ? SCALE_MIN : SCALE_ONE - div_q[16:0];
        S_OUT:  cmd_q  <= sd_q[15] ? 16'(-mag) : mag;
        default: ;
      endcase
    end
    if (st_q == S_PFIN) begin
      dt_q <= dt32[DTW-1:0];
      e1_q <= e_q;
    end
    if (st_q == S_SCL) begin
      priority if (mode_q == MODE_EMERG) scale_q <= '0;
      else if (mode_q != MODE_PROTECT) scale_q <= SCALE_ONE;
      else if (el_q <= pl_q) scale_q <= SCALE_MIN;
      else if (e_q <= pl_q) scale_q <= SCALE_ONE;
      else if (e_pl >= el_pl) scale_q <= SCALE_MIN;
      else scale_q <= scale_q;
    end
    if (st_q == S_DONE && out_free) begin
      out_q <= {4'h0, (mode_q == MODE_EMERG), (mode_q[1] == 1'b1), hp_q, e_q, mode_q, cmd_q};
    end
  end

  mtog_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_st),
    .p_o     (mul_p)
  );

  mtog_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_n),
    .den_i   (div_d),
    .stat_o  (div_st),
    .quo_o   (div_q)
  );

  mtog_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk_i (clk_i),
    .idx_i (idx_q),
    .n_i   (n_q),
    .a_o   (rom_a),
    .b_o   (rom_b),
    .i_o   (rom_i)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  `MTOG_ASSERT_IMP(a_units_exclusive, mul_st.busy, !div_st.busy)
  `MTOG_ASSERT_IMP(a_emerg_implies_prot, m_axis_tvalid && m_axis_tdata[83], m_axis_tdata[82])
  `MTOG_ASSERT_NXT(a_accept_blocks, accept, !s_axis_tready)
  `MTOG_ASSERT_NXT(a_done_delivers, (st_q == S_DONE) && out_free, m_axis_tvalid)

endmodule

/* rtl/mtog_mul.sv */
// ----------------------------------------------------------------------------
// mtog_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle, stops early
// ----------------------------------------------------------------------------
module mtog_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [mtog_pkg::MA_W-1:0] a_i,
  input  logic [mtog_pkg::MB_W-1:0] b_i,
  output mtog_pkg::unit_stat_t     stat_o,
  output logic [mtog_pkg::MP_W-1:0] p_o
);
  import mtog_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [MP_W-1:0] acc_q;
  logic [MP_W-1:0] ash_q;
  logic [MB_W-1:0] bsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bsh_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= MP_W'(a_i);
      bsh_q <= b_i;
    end else if (busy_q && (bsh_q != '0)) begin
      if (bsh_q[0]) acc_q <= acc_q + ash_q;
      ash_q <= ash_q << 1;
      bsh_q <= bsh_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule

/* rtl/mtog_div.sv */
// ----------------------------------------------------------------------------
// mtog_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mtog_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mtog_pkg::DN_W-1:0] num_i,
  input  logic [mtog_pkg::DV_W-1:0] den_i,
  output mtog_pkg::unit_stat_t      stat_o,
  output logic [mtog_pkg::DN_W-1:0] quo_o
);
  import mtog_pkg::*;

  localparam int CW = $clog2(DN_W + 1);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [DV_W-1:0] rem_q;
  logic [DN_W-1:0] quo_q;
  logic [DV_W-1:0] den_q;
  logic [DV_W:0]   trial;
  logic [DV_W+1:0] diff;

  assign trial = {rem_q, quo_q[DN_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DV_W+1]) rem_q <= diff[DV_W-1:0];
      else rem_q <= trial[DV_W-1:0];
      quo_q <= {quo_q[DN_W-2:0], ~diff[DV_W+1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

/* rtl/mtog_exp_rom.sv */
// ----------------------------------------------------------------------------
// mtog_exp_rom
// decay tables: fractional exp(-f) grid and integer powers exp(-n), registered
// ----------------------------------------------------------------------------
module mtog_exp_rom #(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] idx_i,
  input  logic [4:0]               n_i,
  output logic [32:0]              a_o,
  output logic [32:0]              b_o,
  output logic [32:0]              i_o
);
  import mtog_pkg::*;

  localparam logic [63:0] R_STEP = exp_series(64'h1_0000_0000 / 64'(DEPTH - 1));

  logic [32:0] frac_tab [DEPTH];
  logic [32:0] int_tab  [32];

  for (genvar g = 0; g < DEPTH; g++) begin : g_frac
    assign frac_tab[g] = frac_entry(g, R_STEP);
  end

  for (genvar g = 0; g < 32; g++) begin : g_int
    assign int_tab[g] = int_entry(g);
  end

  always_ff @(posedge clk_i) begin
    a_o <= frac_tab[idx_i];
    b_o <= frac_tab[idx_i + 1'b1];
    i_o <= int_tab[n_i];
  end

endmodule

/* tb/sv/tb_motor_thermal_overload_guard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_thermal_overload_guard
// self-checking bench: directed table then heating and cooling sequences under
// several register settings, every result checked against a bit-true model
// ----------------------------------------------------------------------------
module tb_motor_thermal_overload_guard;
  import mtog_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_STEP = 1'b1;
  localparam int STEP_MAX_MS = 2000;
  localparam int TAB_DEPTH   = 256;
  localparam int N_INT       = 24;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 700;
  localparam logic [63:0] ONE32 = 64'h1_0000_0000;
  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic        emerg;
    logic        prot;
    logic [31:0] power;
    logic [31:0] energy;
    logic [1:0]  mode;
    logic [15:0] cmd;
  } guard_out_t;

  typedef struct {
    logic        kind;
    logic [15:0] duty;
    logic [15:0] speed;
    logic [31:0] ms;
    logic        known;
    logic [15:0] k_cmd;
    logic [1:0]  k_mode;
    logic [31:0] k_energy;
  } beat_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  motor_thermal_overload_guard dut (.*);

  // model registers and state
  logic [31:0] r_supply, r_resist, r_bemf, r_tau, r_prot, r_emerg, r_switch;
  logic [1:0]  g_mode;
  logic [31:0] g_energy, g_power, g_last_ms;
  logic [15:0] g_duty, g_speed;
  logic [63:0] frac_lut [TAB_DEPTH];
  logic [63:0] int_lut [N_INT];

  guard_out_t expected_q [$];
  int errors = 0;
  int idle_cycles = 0;
  logic [31:0] cur_ms;

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] m);
    return (a >> 32) * m + (((a & MASK32) * m) >> 32);
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] h);
    logic [63:0] acc, t;
    acc = ONE32;
    t = ONE32;
    for (int k = 1; k <= 16; k++) begin
      t = fx_mul(t, h) / k;
      if (k % 2) acc = acc - t;
      else acc = acc + t;
    end
    return acc;
  endfunction

  function automatic void build_luts();
    logic [63:0] r1, e1;
    r1 = exp_neg(ONE32 / (TAB_DEPTH - 1));
    e1 = exp_neg(ONE32);
    frac_lut[0] = ONE32;
    for (int k = 1; k < TAB_DEPTH; k++) frac_lut[k] = fx_mul(frac_lut[k-1], r1);
    int_lut[0] = ONE32;
    for (int k = 1; k < N_INT; k++) int_lut[k] = fx_mul(int_lut[k-1], e1);
  endfunction

  function automatic logic [63:0] decay(input logic [63:0] dt, input logic [63:0] tau);
    logic [63:0] x, n, pos, idx, a, b;
    x = (dt << 32) / tau;
    n = x >> 32;
    if (n >= N_INT) return 64'd0;
    pos = (x & MASK32) * (TAB_DEPTH - 1);
    idx = pos >> 32;
    if (idx > TAB_DEPTH - 2) idx = TAB_DEPTH - 2;
    a = frac_lut[idx];
    b = frac_lut[idx + 1];
    return fx_mul(int_lut[n], a - fx_mul(a - b, pos & MASK32));
  endfunction

  function automatic logic [63:0] mag16(input logic [15:0] v);
    return v[15] ? 64'd65536 - v : 64'(v);
  endfunction

  function automatic logic [31:0] heat(input logic [15:0] duty, input logic [15:0] speed);
    logic [63:0] ad, as, r, drv, emf, veff, p;
    ad = mag16(duty);
    as = mag16(speed);
    r = (r_resist == 0) ? 64'd1 : 64'(r_resist);
    drv = (64'(r_supply) * ad) >> 7;
    emf = (64'(r_bemf) * as) >> 8;
    veff = (drv > emf) ? drv - emf : 64'd0;
    p = (veff * veff) / (r << 8);
    p = p + FRIC_BASE + ((as * FRIC_SLOPE) >> 8);
    p = p + (((SW_BASE + ((ad * SW_SLOPE) >> 15)) * 64'(r_switch)) >> 8);
    if (ad > STALL_DUTY && as < STALL_SPEED) p = (p * 5) >> 1;
    return (p > MASK32) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [63:0] derate();
    logic [63:0] e, pl, el, num, den, red;
    e = g_energy;
    pl = r_prot;
    el = r_emerg;
    if (g_mode == MODE_EMERG) return 64'd0;
    if (g_mode != MODE_PROTECT) return 64'd65536;
    if (el <= pl) return 64'd39322;
    if (e <= pl) return 64'd65536;
    num = e - pl;
    den = el - pl;
    if (num >= den) return 64'd39322;
    red = (num << 17) / (den * 5);
    return (65536 - red < 39322) ? 64'd39322 : 64'd65536 - red;
  endfunction

  function automatic guard_out_t guard_step(input logic kind, input logic [15:0] duty,
                                            input logic [15:0] speed, input logic [31:0] ms);
    guard_out_t o;
    logic [31:0] dt;
    logic [63:0] tau, d, e, pl, el, sc, mg;
    if (kind == KIND_CMD) begin
      g_duty = duty;
      g_speed = speed;
    end
    g_power = heat(g_duty, g_speed);
    if (g_last_ms == 0) begin
      g_last_ms = ms;
    end else begin
      dt = ms - g_last_ms;
      g_last_ms = ms;
      if (dt != 0 && dt <= STEP_MAX_MS) begin
        tau = (r_tau == 0) ? 64'd1 : 64'(r_tau);
        d = decay(64'(dt), tau);
        e = fx_mul(64'(g_energy), d) + fx_mul(64'(g_power) * tau, ONE32 - d) / 1000;
        g_energy = (e > MASK32) ? 32'hFFFF_FFFF : e[31:0];
      end
    end
    e = g_energy;
    pl = r_prot;
    el = r_emerg;
    case (g_mode)
      MODE_NORMAL: if (e * 100 > pl * 95) g_mode = MODE_ELEVATED;
      MODE_ELEVATED: begin
        if (e > pl) g_mode = MODE_PROTECT;
        else if (e * 100 < pl * 85) g_mode = MODE_NORMAL;
      end
      MODE_PROTECT: begin
        if (e > el) g_mode = MODE_EMERG;
        else if (e * 2 < pl) g_mode = MODE_NORMAL;
      end
      default: if (e * 10 < el * 4) g_mode = MODE_NORMAL;
    endcase
    sc = derate();
    mg = (mag16(g_duty) * sc) >> 16;
    o.cmd = g_duty[15] ? 16'(64'd65536 - mg) : mg[15:0];
    o.mode = g_mode;
    o.energy = g_energy;
    o.power = g_power;
    o.prot = (g_mode >= MODE_PROTECT);
    o.emerg = (g_mode == MODE_EMERG);
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // predictor and checker, sampled at the rising edge
  always @(posedge clk_i) begin
    guard_out_t got, want;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUPPLY: r_supply = cfg_data_i & 32'hFFFF;
        CFG_RESIST: r_resist = cfg_data_i & 32'hFFFF;
        CFG_BEMF:   r_bemf   = cfg_data_i & 32'hFFFF;
        CFG_TAU:    r_tau    = cfg_data_i & 32'hF_FFFF;
        CFG_PROT:   r_prot   = cfg_data_i;
        CFG_EMERG:  r_emerg  = cfg_data_i;
        CFG_SWITCH: r_switch = cfg_data_i & 32'hFFFF;
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready && rst_ni)
      expected_q.push_back(guard_step(s_axis_tuser, s_axis_tdata[15:0],
                                      s_axis_tdata[31:16], s_axis_tdata[63:32]));
    if (m_axis_tvalid && m_axis_tready && rst_ni) begin
      got = m_axis_tdata[83:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.cmd !== want.cmd)
          $display("%0t: limited_command exp %h got %h", $time, want.cmd, got.cmd);
        if (got.mode !== want.mode)
          $display("%0t: state_code exp %0d got %0d", $time, want.mode, got.mode);
        if (got.energy !== want.energy)
          $display("%0t: energy exp %h got %h", $time, want.energy, got.energy);
        if (got.power !== want.power)
          $display("%0t: power exp %h got %h", $time, want.power, got.power);
        if (got.prot !== want.prot)
          $display("%0t: protection_active exp %b got %b", $time, want.prot, got.prot);
        if (got.emerg !== want.emerg)
          $display("%0t: emergency_active exp %b got %b", $time, want.emerg, got.emerg);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // result side stalls
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (n) @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
  end

  task automatic send_beat(input logic kind, input logic [15:0] duty,
                           input logic [15:0] speed, input logic [31:0] ms);
    int g;
    logic hit;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {ms, speed, duty};
    do begin
      @(posedge clk_i);
      hit = s_axis_tready;
    end while (!hit);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(input logic [31:0] v [7]);
    write_reg(CFG_SUPPLY, v[0]);
    write_reg(CFG_RESIST, v[1]);
    write_reg(CFG_BEMF, v[2]);
    write_reg(CFG_TAU, v[3]);
    write_reg(CFG_PROT, v[4]);
    write_reg(CFG_EMERG, v[5]);
    write_reg(CFG_SWITCH, v[6]);
  endtask

  function automatic logic [15:0] pick_duty();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 127));
      1: return -16'($urandom_range(0, 127));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] next_ms(input logic [31:0] ms);
    case ($urandom_range(0, 19))
      0: return ms;
      1: return ms + $urandom_range(STEP_MAX_MS + 1, 100000);
      2: return 32'($urandom);
      3: return ($urandom_range(0, 3) == 0) ? 32'd0 : ms + STEP_MAX_MS;
      4, 5, 6: return ms + $urandom_range(1, 50);
      default: return ms + $urandom_range(200, STEP_MAX_MS);
    endcase
  endfunction

  beat_row_t dir_rows [] = '{
    '{KIND_CMD,  16'h7FFF, 16'h0000, 32'd100,   1'b1, 16'h7FFF, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'hFFFF, 16'hFFFF, 32'd100,   1'b1, 16'h7FFF, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd2100,  1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h8000, 16'h007F, 32'd4100,  1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd6100,  1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd8100,  1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd10100, 1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h7FFF, 16'h7FFF, 32'd12101, 1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h2667, 16'h8000, 32'd12101, 1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h2666, 16'h0080, 32'd12102, 1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h0000, 16'h0000, 32'd13000, 1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd0,     1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h8001, 16'hFF81, 32'd0,     1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'hFFFF_FF00, 1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd500,   1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_CMD,  16'h8000, 16'h0000, 32'd2500,  1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd4500,  1'b0, 16'h0, MODE_NORMAL, 32'd0},
    '{KIND_STEP, 16'h0000, 16'h0000, 32'd6500,  1'b0, 16'h0, MODE_NORMAL, 32'd0}
  };

  // directed rows with typed-in values are checked on top of the model
  always @(posedge clk_i) begin : known_check
    static int row = 0;
    if (m_axis_tvalid && m_axis_tready && rst_ni && row < dir_rows.size()) begin
      if (dir_rows[row].known &&
          (m_axis_tdata[15:0] !== dir_rows[row].k_cmd ||
           m_axis_tdata[17:16] !== dir_rows[row].k_mode ||
           m_axis_tdata[49:18] !== dir_rows[row].k_energy)) begin
        $display("%0t: row %0d exp %h/%0d/%h got %h/%0d/%h", $time, row,
                 dir_rows[row].k_cmd, dir_rows[row].k_mode, dir_rows[row].k_energy,
                 m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tdata[49:18]);
        errors++;
      end
      row++;
    end
  end

  initial begin
    logic [31:0] regs [7];
    int n_phase;
    build_luts();
    r_supply = 3072; r_resist = 512; r_bemf = 655; r_tau = 30000;
    r_prot = 6553600; r_emerg = 9830400; r_switch = 256;
    g_mode = MODE_NORMAL; g_energy = 0; g_power = 0; g_last_ms = 0;
    g_duty = 0; g_speed = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_SUPPLY; cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    regs = '{32'd3072, 32'd512, 32'd655, 32'd30000, 32'd6553600, 32'd9830400, 32'd256};
    load_regs(regs);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].duty, dir_rows[i].speed, dir_rows[i].ms);
    cur_ms = 32'd6500;

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      case (ph)
        0: regs = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd600000, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF};
        1: regs = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        2: regs = '{32'd3072, 32'd512, 32'd655, 32'd300, 32'd6553600, 32'd3276800, 32'd256};
        3: regs = '{32'd3072, 32'd512, 32'd655, 32'd30000, 32'd6553600, 32'd9830400, 32'd256};
        default: begin
          regs[0] = $urandom_range(0, 65535);
          regs[1] = ($urandom_range(0, 1)) ? $urandom_range(1, 2048) : $urandom;
          regs[2] = $urandom;
          regs[3] = ($urandom_range(0, 1)) ? $urandom_range(1, 5000) : $urandom;
          regs[4] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 26);
          regs[5] = ($urandom_range(0, 3) == 0) ? $urandom
                                                : regs[4] + $urandom_range(0, 1 << 26);
          regs[6] = $urandom;
        end
      endcase
      load_regs(regs);
      if (ph == 1) write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
      n_phase = (ph == 8) ? 230 : 165;
      for (int i = 0; i < n_phase; i++) begin
        logic [15:0] dv, sv;
        logic kd;
        dv = pick_duty();
        sv = pick_speed();
        kd = ($urandom_range(0, 2) == 0) ? KIND_STEP : KIND_CMD;
        // bursts of random command alternate with cooling blocks at duty 500 or less
        if ((i / 20) % 2 == 1 && kd == KIND_CMD) dv = 16'($urandom_range(0, 500));
        cur_ms = next_ms(cur_ms);
        send_beat(kd, dv, sv, cur_ms);
      end
    end

    drain();
    if (expected_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mtog_pkg.sv
rtl/mtog_mul.sv
rtl/mtog_div.sv
rtl/mtog_exp_rom.sv
rtl/motor_thermal_overload_guard.sv
tb/sv/tb_motor_thermal_overload_guard.sv
